// ----- sv/acs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS      = 10;
  localparam int SAMPLES_AVERAGED = 4;
  localparam int COUNT_W          = $clog2(SAMPLES_AVERAGED);
  localparam int SUM_W            = SAMPLE_BITS + COUNT_W;
  localparam int CH_PORT_W        = 3;
  localparam int ENABLE_W         = 8;
  localparam int BITS_W           = 4;
  localparam int CFG_ADDR_W       = 4;

  // operation codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_ENABLE = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_CHANNEL  = 4'd1;

  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [CH_PORT_W-1:0]   read_channel;
    logic [BITS_W-1:0]      read_bits;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic [CH_PORT_W-1:0]   value_channel;
    logic                   average_stored;
    logic [CH_PORT_W-1:0]   mux_channel;
    logic                   no_channel;
  } out_item_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [ENABLE_W-1:0]   wdata;
  } cfg_req_t;

  // controller to datapath commands
  typedef struct packed {
    logic take_item;
    logic write_enable;
    logic write_start;
  } acs_cmd_t;

  // output register occupancy
  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } acs_state_t;

endpackage

`default_nettype wire

// ----- sv/acs_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface acs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/acs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module acs_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [acs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  output acs_pkg::acs_cmd_t                   cmd
);

  acs_pkg::acs_state_t state;
  acs_pkg::acs_state_t state_next;
  logic                take;

  assign take = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acs_pkg::ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // next state: full while a result waits, refilled on a new request
  always_comb begin
    state_next = state;
    case (state)
      acs_pkg::ST_EMPTY: begin
        if (take) state_next = acs_pkg::ST_FULL;
      end
      acs_pkg::ST_FULL: begin
        if (out_ready && !take) state_next = acs_pkg::ST_EMPTY;
      end
      default: state_next = acs_pkg::ST_EMPTY;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      acs_pkg::ST_EMPTY: begin
        in_ready = 1'b1;
      end
      acs_pkg::ST_FULL: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
    cfg_ready         = 1'b1;
    cmd.take_item     = in_valid && in_ready;
    cmd.write_enable  = cfg_valid && (cfg_addr == acs_pkg::CFG_CHANNEL_ENABLE);
    cmd.write_start   = cfg_valid && (cfg_addr == acs_pkg::CFG_START_CHANNEL);
  end

  // a held result is not dropped unless the sink took it
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ----- sv/acs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module acs_datapath #(
  parameter int CHANNELS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire acs_pkg::acs_cmd_t            cmd,
  input  wire acs_pkg::in_item_t            item,
  input  wire logic [acs_pkg::ENABLE_W-1:0] cfg_wdata,
  output acs_pkg::out_item_t                result
);

  localparam int CH_W = $clog2(CHANNELS);

  logic [acs_pkg::SUM_W-1:0]       sample_sum;
  logic [acs_pkg::COUNT_W-1:0]     sample_count;
  logic [CH_W-1:0]                 active_channel;
  logic [acs_pkg::ENABLE_W-1:0]    channel_enable;
  logic [acs_pkg::SAMPLE_BITS-1:0] channel_value [CHANNELS];

  logic [acs_pkg::ENABLE_W-1:0]    en_mask;
  logic                            none;
  logic [acs_pkg::SUM_W-1:0]       sum_total;
  logic                            count_full;
  logic [acs_pkg::SAMPLE_BITS-1:0] average;
  logic [CH_W-1:0]                 next_channel;
  logic [CH_W-1:0]                 start_mod;
  logic [4:0]                      rch_wide;
  logic [CH_W-1:0]                 read_idx;
  logic [acs_pkg::BITS_W-1:0]      shift;
  logic [acs_pkg::SAMPLE_BITS-1:0] read_value;
  logic [4:0]                      active_wide;
  acs_pkg::out_item_t              result_next;
  logic [CH_W-1:0]                 active_after;

  // enables exist only for channels below 8 and below CHANNELS
  always_comb begin
    for (int j = 0; j < acs_pkg::ENABLE_W; j++) begin
      en_mask[j] = channel_enable[j] && (j < CHANNELS);
    end
  end
  assign none = ~|en_mask;

  // accumulator
  assign sum_total  = sample_sum + acs_pkg::SUM_W'(item.sample_value);
  assign count_full = (sample_count == acs_pkg::COUNT_W'(acs_pkg::SAMPLES_AVERAGED - 1));
  assign average    = sum_total[acs_pkg::SUM_W-1:acs_pkg::COUNT_W];

  // rotating priority search, one above active and wrapping to itself
  always_comb begin
    logic [4:0] cand;
    next_channel = active_channel;
    for (int i = CHANNELS; i >= 1; i--) begin
      cand = 5'(active_channel) + 5'(i);
      if (cand >= 5'(CHANNELS)) cand = cand - 5'(CHANNELS);
      if ((cand < 5'd8) && en_mask[cand[2:0]]) next_channel = cand[CH_W-1:0];
    end
  end

  // start channel reduced modulo CHANNELS: small constant table
  always_comb begin
    start_mod = '0;
    for (int i = 0; i < 8; i++) begin
      if (cfg_wdata[2:0] == 3'(i)) start_mod = CH_W'(i % CHANNELS);
    end
  end

  // read path
  assign rch_wide = 5'(item.read_channel);
  assign read_idx = rch_wide[CH_W-1:0];
  assign shift = (item.read_bits >= acs_pkg::BITS_W'(acs_pkg::SAMPLE_BITS)) ? '0 :
                 acs_pkg::BITS_W'(acs_pkg::SAMPLE_BITS) - item.read_bits;
  assign read_value = (rch_wide < 5'(CHANNELS)) ? (channel_value[read_idx] >> shift) : '0;

  // result of the item being taken
  always_comb begin
    active_after = active_channel;
    result_next.value          = '0;
    active_wide                = 5'(active_channel);
    result_next.value_channel  = active_wide[2:0];
    result_next.average_stored = 1'b0;
    if (item.func == acs_pkg::FUNC_SAMPLE) begin
      if (count_full) begin
        result_next.value          = average;
        result_next.average_stored = 1'b1;
        if (!none) active_after = next_channel;
      end
    end else begin
      result_next.value         = read_value;
      result_next.value_channel = item.read_channel;
    end
    result_next.mux_channel = 3'(active_after);
    result_next.no_channel  = none;
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum     <= '0;
      sample_count   <= '0;
      active_channel <= '0;
      channel_enable <= '0;
    end else begin
      if (cmd.write_enable) channel_enable <= cfg_wdata;
      if (cmd.write_start) begin
        active_channel <= start_mod;
        sample_sum     <= '0;
        sample_count   <= '0;
      end else if (cmd.take_item && (item.func == acs_pkg::FUNC_SAMPLE)) begin
        active_channel <= active_after;
        if (count_full) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_total;
          sample_count <= sample_count + 1'b1;
        end
      end
    end
  end

  // stored averages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) channel_value[k] <= '0;
    end else if (cmd.take_item && (item.func == acs_pkg::FUNC_SAMPLE) && count_full) begin
      channel_value[active_channel] <= average;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.take_item) result <= result_next;
  end

  a_active_range: assert property (@(posedge clk) disable iff (rst)
    (5'(active_channel) < 5'(CHANNELS)))
    else $error("active channel out of range");

  a_hold_when_none: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_item && (item.func == acs_pkg::FUNC_SAMPLE) && none && !cmd.write_start)
    |=> $stable(active_channel))
    else $error("scan moved with no channel enabled");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.write_start |=> (sample_count == '0) && (sample_sum == '0))
    else $error("scan restart left accumulator dirty");

  a_read_no_store: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_item && (item.func == acs_pkg::FUNC_READ)) |=> !result.average_stored)
    else $error("read flagged as stored average");

endmodule

`default_nettype wire

// ----- sv/adc_scan_average_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Role    Payload
// item     sink    func, sample_value, read_channel, read_bits
// result   source  value, value_channel, average_stored, mux_channel, no_channel
// cfg      sink    addr (0 channel_enable, 1 start_channel), wdata
//
// Each request's result is registered and shows the next cycle. One output
// register sets the rate: a new request is taken whenever that register is
// empty or being drained, so one per cycle.
// Synchronous reset clears the scan state, the enables and the stored averages.
// A stalled result holds, and item stalls only while the result waits.
// cfg is always ready and takes effect the next cycle.
module adc_scan_average_sequencer #(
  parameter int CHANNELS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  acs_stream_if.sink   item,
  acs_stream_if.source result,
  acs_stream_if.sink   cfg
);

  acs_pkg::acs_cmd_t  cmd;
  acs_pkg::in_item_t  item_data;
  acs_pkg::cfg_req_t  cfg_data;
  acs_pkg::out_item_t result_data;

  assign item_data   = item.data;
  assign cfg_data    = cfg.data;
  assign result.data = result_data;

  acs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_addr  (cfg_data.addr),
    .cmd       (cmd)
  );

  acs_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item_data),
    .cfg_wdata (cfg_data.wdata),
    .result    (result_data)
  );

endmodule

`default_nettype wire

// ----- dv/adc_scan_average_sequencer_tb.sv -----
`timescale 1ns / 1ps

module adc_scan_average_sequencer_tb;

  localparam int NUM_CH      = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_CHUNKS = 6;
  localparam int CHUNK_ITEMS  = 75;

  // Predicts the scan/average behavior and holds the results still owed
  class scan_average_model;
    logic [acs_pkg::ENABLE_W-1:0]    enable_mask;
    logic [acs_pkg::CH_PORT_W-1:0]   active_ch;
    int unsigned                     sum;
    int unsigned                     count;
    logic [acs_pkg::SAMPLE_BITS-1:0] stored_avg [NUM_CH];
    acs_pkg::out_item_t              owed_results [$];
    int                              mismatches;

    function new();
      enable_mask = '0;
      active_ch   = '0;
      sum         = 0;
      count       = 0;
      foreach (stored_avg[i]) stored_avg[i] = '0;
      mismatches  = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void write_reg(acs_pkg::cfg_req_t req);
      if (req.addr == acs_pkg::CFG_CHANNEL_ENABLE) begin
        enable_mask = req.wdata;
      end else if (req.addr == acs_pkg::CFG_START_CHANNEL) begin
        // restart the scan at the new channel; stored averages stay
        active_ch = req.wdata[acs_pkg::CH_PORT_W-1:0];
        sum       = 0;
        count     = 0;
      end
    endfunction

    // rotating search, starting one above and ending at the current channel
    function logic [acs_pkg::CH_PORT_W-1:0] next_enabled(
      logic [acs_pkg::CH_PORT_W-1:0] from);
      logic [acs_pkg::CH_PORT_W-1:0] ch;
      ch = from;
      for (int i = 0; i < NUM_CH; i++) begin
        ch = ch + 1'b1;
        if (enable_mask[ch]) return ch;
      end
      return from;
    endfunction

    function void take_request(acs_pkg::in_item_t req);
      acs_pkg::out_item_t rep;
      logic               none;
      int                 shift;
      none = (enable_mask == '0);
      rep = '0;
      rep.value_channel = active_ch;
      if (req.func == acs_pkg::FUNC_SAMPLE) begin
        sum += req.sample_value;
        count++;
        if (count >= acs_pkg::SAMPLES_AVERAGED) begin
          rep.value = acs_pkg::SAMPLE_BITS'(sum / acs_pkg::SAMPLES_AVERAGED);
          stored_avg[active_ch] = rep.value;
          rep.average_stored = 1'b1;
          if (!none) active_ch = next_enabled(active_ch);
          sum   = 0;
          count = 0;
        end
      end else begin
        shift = (req.read_bits >= acs_pkg::SAMPLE_BITS) ? 0 :
                acs_pkg::SAMPLE_BITS - int'(req.read_bits);
        rep.value_channel = req.read_channel;
        rep.value = stored_avg[req.read_channel] >> shift;
      end
      rep.mux_channel = active_ch;
      rep.no_channel  = none;
      owed_results.push_back(rep);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(acs_pkg::out_item_t got);
      acs_pkg::out_item_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value=%0d channel=%0d",
                 $time, got.value, got.value_channel);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      check_field("value", want.value, got.value);
      check_field("value_channel", want.value_channel, got.value_channel);
      check_field("average_stored", want.average_stored, got.average_stored);
      check_field("mux_channel", want.mux_channel, got.mux_channel);
      check_field("no_channel", want.no_channel, got.no_channel);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle;
  int   sink_idle;
  int   cycles;

  scan_average_model scan = new();

  acs_stream_if #(.T(acs_pkg::in_item_t))  item_ch ();
  acs_stream_if #(.T(acs_pkg::out_item_t)) result_ch ();
  acs_stream_if #(.T(acs_pkg::cfg_req_t))  cfg_ch ();

  adc_scan_average_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // monitor: all handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) scan.check_result(result_ch.data);
      if (item_ch.valid && item_ch.ready) scan.take_request(item_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) scan.write_reg(cfg_ch.data);
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst) result_ch.ready = ($urandom_range(0, 99) >= sink_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(acs_pkg::in_item_t req);
    while ($urandom_range(0, 99) < src_idle) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.data  = req;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // register writes only once every result is back
  task automatic write_cfg(logic [acs_pkg::CFG_ADDR_W-1:0] addr,
                           logic [acs_pkg::ENABLE_W-1:0] wdata);
    item_ch.valid = 1'b0;
    while (scan.pending() != 0) @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.data.addr  = addr;
    cfg_ch.data.wdata = wdata;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic acs_pkg::in_item_t sample_req(logic [acs_pkg::SAMPLE_BITS-1:0] v);
    acs_pkg::in_item_t req;
    req.func         = acs_pkg::FUNC_SAMPLE;
    req.sample_value = v;
    req.read_channel = acs_pkg::CH_PORT_W'($urandom_range(0, NUM_CH - 1));
    req.read_bits    = acs_pkg::BITS_W'($urandom_range(0, 15));
    return req;
  endfunction

  function automatic acs_pkg::in_item_t read_req(logic [acs_pkg::CH_PORT_W-1:0] ch,
                                                 logic [acs_pkg::BITS_W-1:0] bits);
    acs_pkg::in_item_t req;
    req.func         = acs_pkg::FUNC_READ;
    req.sample_value = acs_pkg::SAMPLE_BITS'($urandom_range(0, 1023));
    req.read_channel = ch;
    req.read_bits    = bits;
    return req;
  endfunction

  // mostly conversions so the scan keeps moving, reads in between
  function automatic acs_pkg::in_item_t random_req();
    logic [acs_pkg::SAMPLE_BITS-1:0] v;
    logic [acs_pkg::BITS_W-1:0]      bits;
    if ($urandom_range(0, 99) < 70) begin
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        default: v = acs_pkg::SAMPLE_BITS'($urandom_range(0, 1023));
      endcase
      return sample_req(v);
    end
    bits = ($urandom_range(0, 4) == 0) ? acs_pkg::BITS_W'($urandom_range(0, 15)) :
                                         acs_pkg::BITS_W'($urandom_range(1, 10));
    return read_req(acs_pkg::CH_PORT_W'($urandom_range(0, NUM_CH - 1)), bits);
  endfunction

  task automatic random_config();
    logic [acs_pkg::ENABLE_W-1:0] mask;
    case ($urandom_range(0, 5))
      0:       mask = '0;
      1:       mask = '1;
      2:       mask = 8'd1 << $urandom_range(0, NUM_CH - 1);
      default: mask = acs_pkg::ENABLE_W'($urandom_range(0, 255));
    endcase
    write_cfg(acs_pkg::CFG_CHANNEL_ENABLE, mask);
    if ($urandom_range(0, 1) == 0)
      write_cfg(acs_pkg::CFG_START_CHANNEL, acs_pkg::ENABLE_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0)
      write_cfg(acs_pkg::CFG_ADDR_W'($urandom_range(acs_pkg::CFG_START_CHANNEL + 1,
                                                    (1 << acs_pkg::CFG_ADDR_W) - 1)),
                acs_pkg::ENABLE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    result_ch.ready = 1'b0;
    src_idle        = 0;
    sink_idle       = 0;
    cycles          = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // nothing enabled: average still stored, scan holds on channel 0
    send_request(read_req(3'd0, 4'd10));
    repeat (4) send_request(sample_req('1));
    // resolution extremes, including zero and above full width
    send_request(read_req(3'd0, 4'd0));
    send_request(read_req(3'd0, 4'd15));
    send_request(read_req(3'd0, 4'd1));
    send_request(read_req(3'd0, 4'd10));

    // wrap from the top channel; high wdata bits of start are dropped
    write_cfg(acs_pkg::CFG_CHANNEL_ENABLE, 8'h81);
    write_cfg(acs_pkg::CFG_START_CHANNEL, 8'hFF);
    write_cfg('1, 8'h00);
    repeat (4) send_request(sample_req('0));
    send_request(sample_req('1));
    send_request(sample_req('0));
    send_request(sample_req('1));
    send_request(sample_req(10'd1));
    send_request(read_req(3'd7, 4'd5));
    send_request(read_req(3'd0, 4'd5));
    send_request(read_req(3'd3, 4'd9));

    // all enabled, restart at channel 0 mid-average
    write_cfg(acs_pkg::CFG_CHANNEL_ENABLE, 8'hFF);
    send_request(sample_req(10'd512));
    write_cfg(acs_pkg::CFG_START_CHANNEL, 8'h00);
    repeat (4) send_request(sample_req(10'd3));

    // random traffic in three pressure phases
    for (int ph = 0; ph < 3; ph++) begin
      src_idle  = (ph == 0) ? 31 : (ph == 1) ? 85 : 0;
      sink_idle = (ph == 0) ? 85 : (ph == 1) ? 31 : 0;
      for (int c = 0; c < PHASE_CHUNKS; c++) begin
        random_config();
        repeat (CHUNK_ITEMS) send_request(random_req());
      end
    end
    item_ch.valid = 1'b0;

    while (scan.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (scan.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/acs_pkg.sv
sv/acs_stream_if.sv
sv/acs_ctrl.sv
sv/acs_datapath.sv
sv/adc_scan_average_sequencer.sv
dv/adc_scan_average_sequencer_tb.sv
